[rtl/tws_pkg.sv]
`default_nettype none

package tws_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_W     = 4;
  localparam int FIELD_W  = 12;
  localparam int MIN_W    = 11;
  localparam int SCHED_W  = 48;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 64;

  localparam logic [CH_W-1:0] CH_MASK = CH_W'((1 << CHANNELS) - 1);

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_DRIVE      = 3'd1,
    OP_MAN_DRIVE  = 3'd2,
    OP_SET_MANUAL = 3'd3,
    OP_EVAL_NOW   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_ON_SCHED  = 2'd0,
    REG_OFF_SCHED = 2'd1,
    REG_AUTO      = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]       operation;
    logic [1:0]       channel;
    logic             all_channels;
    logic             level;
    logic [MIN_W-1:0] minute_of_day;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] output_levels;
    logic [CH_W-1:0] manual_flags;
    logic [CH_W-1:0] changed_mask;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/time_window_output_switch_top.sv]
// An accepted item is held in the input register, and its result is written to the
// output register when that register is free or is being read.
// Throughput: one item per cycle; the input stalls only while both the input and
// the output register hold items and out_stall is high.
// Reset (rst_n low, synchronous): all outputs off, all channels automatic,
// no minute recorded, schedules zero, auto mode on, both channels empty.
`default_nettype none

module time_window_output_switch_top import tws_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  logic               in_vld_r, in_vld_nxt;
  in_item_t           in_item_r;
  logic               out_vld_r, out_vld_nxt;
  out_item_t          out_item_r, out_item_nxt;
  logic [SCHED_W-1:0] on_r, off_r;
  logic               auto_r;
  logic [CH_W-1:0]    lv_r, lv_nxt;
  logic [CH_W-1:0]    man_r, man_nxt;
  logic [MIN_W-1:0]   lm_r, lm_nxt;
  logic               lmv_r, lmv_nxt;

  logic               in_acc;
  logic               proc;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;
  logic [CH_W-1:0]    target;
  logic [CH_W-1:0]    man_eval;
  logic [CH_W-1:0]    lv_eval;
  logic [CH_W-1:0]    lv_drive;

  // config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:3]);

  always_comb begin
    unique case (cfg_idx)
      REG_ON_SCHED:  prdata = PDATA_W'(on_r);
      REG_OFF_SCHED: prdata = PDATA_W'(off_r);
      REG_AUTO:      prdata = PDATA_W'(auto_r);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r   <= '0;
      off_r  <= '0;
      auto_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ON_SCHED:  on_r   <= pwdata[SCHED_W-1:0];
        REG_OFF_SCHED: off_r  <= pwdata[SCHED_W-1:0];
        REG_AUTO:      auto_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign proc      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !proc;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  always_comb begin
    in_vld_nxt  = in_acc ? 1'b1 : (proc ? 1'b0 : in_vld_r);
    out_vld_nxt = proc ? 1'b1 : (out_vld_r && out_stall);
  end

  always_comb begin
    target = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      target[i] = in_item_r.all_channels || (in_item_r.channel == 2'(i));
    end
  end

  // clearing a manual flag re-evaluates with the flag already cleared
  assign man_eval = (op_t'(in_item_r.operation) == OP_SET_MANUAL && !in_item_r.level) ?
                    (man_r & ~target) : man_r;
  assign lv_drive = in_item_r.level ? (lv_r | target) : (lv_r & ~target);

  tws_eval u_eval (
    .now         (in_item_r.minute_of_day),
    .on_sched    (on_r),
    .off_sched   (off_r),
    .manual      (man_eval),
    .levels_cur  (lv_r),
    .levels_eval (lv_eval)
  );

  always_comb begin
    lv_nxt  = lv_r;
    man_nxt = man_r;
    lm_nxt  = lm_r;
    lmv_nxt = lmv_r;
    if (proc) begin
      unique case (op_t'(in_item_r.operation))
        OP_TICK: begin
          if (auto_r && (!lmv_r || in_item_r.minute_of_day != lm_r)) begin
            lm_nxt  = in_item_r.minute_of_day;
            lmv_nxt = 1'b1;
            lv_nxt  = lv_eval;
          end
        end
        OP_DRIVE: begin
          lv_nxt = lv_drive;
        end
        OP_MAN_DRIVE: begin
          man_nxt = man_r | target;
          lv_nxt  = lv_drive;
        end
        OP_SET_MANUAL: begin
          if (target != '0) begin
            man_nxt = man_eval | (in_item_r.level ? target : '0);
            if (!in_item_r.level && auto_r) begin
              lv_nxt = lv_eval;
            end
          end
        end
        OP_EVAL_NOW: begin
          if (auto_r) begin
            lv_nxt = lv_eval;
          end
        end
        default: ;
      endcase
      lv_nxt  = lv_nxt & CH_MASK;
      man_nxt = man_nxt & CH_MASK;
    end
    out_item_nxt.output_levels = lv_nxt;
    out_item_nxt.manual_flags  = man_nxt;
    out_item_nxt.changed_mask  = lv_r ^ lv_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      lv_r      <= '0;
      man_r     <= '0;
      lm_r      <= '0;
      lmv_r     <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      lv_r      <= lv_nxt;
      man_r     <= man_nxt;
      lm_r      <= lm_nxt;
      lmv_r     <= lmv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r <= in_data;
    end
    if (proc) begin
      out_item_r <= out_item_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idle_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !proc |=> $stable(lv_r) && $stable(man_r) && $stable(lmv_r))
    else $error("channel state changed without an item");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> out_vld_r && out_item_r.output_levels == lv_r &&
             out_item_r.manual_flags == man_r)
    else $error("result does not match channel state");

  a_drive_keeps_manual: assert property (@(posedge clk) disable iff (!rst_n)
    proc && in_item_r.operation == OP_DRIVE |=> $stable(man_r))
    else $error("drive changed manual flags");

  a_changed_mask: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> out_item_r.changed_mask == (lv_r ^ $past(lv_r)))
    else $error("changed mask wrong");
`endif

endmodule

`default_nettype wire

[rtl/tws_eval.sv]
`default_nettype none

module tws_eval import tws_pkg::*; (
  input  logic [MIN_W-1:0]   now,
  input  logic [SCHED_W-1:0] on_sched,
  input  logic [SCHED_W-1:0] off_sched,
  input  logic [CH_W-1:0]    manual,
  input  logic [CH_W-1:0]    levels_cur,
  output logic [CH_W-1:0]    levels_eval
);

  always_comb begin
    logic [FIELD_W-1:0] onf;
    logic [FIELD_W-1:0] offf;
    logic [MIN_W-1:0]   on_min;
    logic [MIN_W-1:0]   off_min;
    logic               has_on;
    logic               has_off;
    logic               v;
    levels_eval = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      onf     = on_sched[c*FIELD_W +: FIELD_W];
      offf    = off_sched[c*FIELD_W +: FIELD_W];
      has_on  = onf[FIELD_W-1];
      has_off = offf[FIELD_W-1];
      on_min  = onf[MIN_W-1:0];
      off_min = offf[MIN_W-1:0];
      v       = levels_cur[c];
      if (manual[c]) begin
        v = levels_cur[c];
      end else if (has_on && has_off) begin
        // window [on, off), wraps past midnight when on > off
        if (on_min == off_min) begin
          v = 1'b0;
        end else if (on_min < off_min) begin
          v = (now >= on_min) && (now < off_min);
        end else begin
          v = (now >= on_min) || (now < off_min);
        end
      end else begin
        if (has_on && now == on_min) begin
          v = 1'b1;
        end
        if (has_off && now == off_min) begin
          v = 1'b0;
        end
      end
      levels_eval[c] = v;
    end
  end

endmodule

`default_nettype wire

[tb/tws_output_checker.sv]
`timescale 1ns / 100ps

module tws_output_checker import tws_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  out_item_t           out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output int                  errors,
  output int                  pending
);

  // shadow of the block's registers and channel state
  logic [SCHED_W-1:0] on_sched;
  logic [SCHED_W-1:0] off_sched;
  logic               auto_on;
  logic [CH_W-1:0]    lvl_bits;
  logic [CH_W-1:0]    man_bits;
  logic [MIN_W-1:0]   last_min;
  logic               last_ok;

  out_item_t status_due[$];
  out_item_t want;
  int        tally = 0;

  function automatic void apply_schedule(logic [MIN_W-1:0] now);
    logic [FIELD_W-1:0] onf;
    logic [FIELD_W-1:0] offf;
    logic [MIN_W-1:0]   on_m;
    logic [MIN_W-1:0]   off_m;
    logic               win;
    if (!auto_on) return;
    for (int c = 0; c < CHANNELS; c++) begin
      onf   = on_sched[c*FIELD_W +: FIELD_W];
      offf  = off_sched[c*FIELD_W +: FIELD_W];
      on_m  = onf[MIN_W-1:0];
      off_m = offf[MIN_W-1:0];
      if (man_bits[c]) continue;
      if (onf[FIELD_W-1] && offf[FIELD_W-1]) begin
        // window [on, off), wraps past midnight when on > off
        if (on_m == off_m)
          win = 1'b0;
        else if (on_m < off_m)
          win = (now >= on_m) && (now < off_m);
        else
          win = (now >= on_m) || (now < off_m);
        lvl_bits[c] = win;
      end else begin
        if (onf[FIELD_W-1] && now == on_m) lvl_bits[c] = 1'b1;
        if (offf[FIELD_W-1] && now == off_m) lvl_bits[c] = 1'b0;
      end
    end
  endfunction

  function automatic out_item_t switch_status(in_item_t it);
    logic [CH_W-1:0] prev;
    logic [CH_W-1:0] tgt;
    out_item_t       r;
    prev = lvl_bits;
    if (it.all_channels)
      tgt = CH_MASK;
    else if (it.channel < CHANNELS)
      tgt = CH_W'(1) << it.channel;
    else
      tgt = '0;
    case (it.operation)
      OP_TICK: begin
        if (auto_on && (!last_ok || it.minute_of_day != last_min)) begin
          last_min = it.minute_of_day;
          last_ok  = 1'b1;
          apply_schedule(it.minute_of_day);
        end
      end
      OP_DRIVE: begin
        lvl_bits = it.level ? (lvl_bits | tgt) : (lvl_bits & ~tgt);
      end
      OP_MAN_DRIVE: begin
        man_bits = man_bits | tgt;
        lvl_bits = it.level ? (lvl_bits | tgt) : (lvl_bits & ~tgt);
      end
      OP_SET_MANUAL: begin
        if (tgt != '0) begin
          if (it.level) begin
            man_bits = man_bits | tgt;
          end else begin
            man_bits = man_bits & ~tgt;
            apply_schedule(it.minute_of_day);
          end
        end
      end
      OP_EVAL_NOW: begin
        apply_schedule(it.minute_of_day);
      end
      default: ;
    endcase
    lvl_bits = lvl_bits & CH_MASK;
    man_bits = man_bits & CH_MASK;
    r.output_levels = lvl_bits;
    r.manual_flags  = man_bits;
    r.changed_mask  = prev ^ lvl_bits;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      on_sched  = '0;
      off_sched = '0;
      auto_on   = 1'b1;
      lvl_bits  = '0;
      man_bits  = '0;
      last_min  = '0;
      last_ok   = 1'b0;
      status_due.delete();
      tally = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:3])
          REG_ON_SCHED:  on_sched = pwdata[SCHED_W-1:0];
          REG_OFF_SCHED: off_sched = pwdata[SCHED_W-1:0];
          REG_AUTO:      auto_on = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        status_due.insert(status_due.size(), switch_status(in_data));
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          $error("result with no item outstanding: %h", out_data);
          tally++;
        end else begin
          want = status_due.pop_front();
          if (out_data.output_levels !== want.output_levels) begin
            $error("output_levels: expected %h, got %h",
                   want.output_levels, out_data.output_levels);
            tally++;
          end
          if (out_data.manual_flags !== want.manual_flags) begin
            $error("manual_flags: expected %h, got %h",
                   want.manual_flags, out_data.manual_flags);
            tally++;
          end
          if (out_data.changed_mask !== want.changed_mask) begin
            $error("changed_mask: expected %h, got %h",
                   want.changed_mask, out_data.changed_mask);
            tally++;
          end
        end
      end
    end
    errors  <= tally;
    pending <= status_due.size();
  end

endmodule

[tb/time_window_output_switch_top_test.sv]
`timescale 1ns / 100ps

module time_window_output_switch_top_test;
  import tws_pkg::*;

  localparam int         QUIET_LIMIT    = 2000;
  localparam int         HOLD_CYCLES    = 48;
  localparam int         PHASE_ITEMS    = 130;
  localparam int         PHASES         = 8;
  localparam int         DAY_MINUTES    = 1440;
  localparam int         MAX_GAP        = 8;
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;  // codes the block ignores
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int errors;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int quiet = 0;
  int walk = 0;
  logic [MIN_W-1:0] pool [4];

  time_window_output_switch_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  tws_output_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic in_item_t mk_item(logic [2:0] op, logic [1:0] ch, logic all,
                                       logic lvl, logic [MIN_W-1:0] minute);
    in_item_t it;
    it.operation     = op;
    it.channel       = ch;
    it.all_channels  = all;
    it.level         = lvl;
    it.minute_of_day = minute;
    return it;
  endfunction

  function automatic logic [FIELD_W-1:0] sched_fld(logic en, logic [MIN_W-1:0] minute);
    return {en, minute};
  endfunction

  // mostly minutes that hit the schedule or walk forward like a clock, some random
  function automatic logic [MIN_W-1:0] pick_minute();
    int r;
    r = $urandom_range(99);
    if (r < 45) return pool[$urandom_range(3)];
    if (r < 80) begin
      walk = (walk + $urandom_range(2)) % DAY_MINUTES;
      return MIN_W'(walk);
    end
    return MIN_W'($urandom_range(2047));
  endfunction

  function automatic logic [SCHED_W-1:0] make_sched();
    logic [SCHED_W-1:0] s;
    logic [MIN_W-1:0]   m;
    logic               en;
    s = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      m  = ($urandom_range(9) == 0) ? MIN_W'($urandom_range(2047)) : pool[$urandom_range(3)];
      en = ($urandom_range(3) != 0);
      s[c*FIELD_W +: FIELD_W] = sched_fld(en, m);
    end
    return s;
  endfunction

  function automatic in_item_t random_item();
    int         r;
    logic [2:0] op;
    r = $urandom_range(99);
    if (r < 50)      op = OP_TICK;
    else if (r < 60) op = OP_EVAL_NOW;
    else if (r < 70) op = OP_DRIVE;
    else if (r < 80) op = OP_MAN_DRIVE;
    else if (r < 95) op = OP_SET_MANUAL;
    else             op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
    return mk_item(op, 2'($urandom_range(3)), ($urandom_range(3) == 0),
                   1'($urandom_range(1)), pick_minute());
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // sender pauses until every outstanding result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int mode;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ch0 plain window, ch1 wraps midnight, ch2 equal times, ch3 on-only
    cfg_write(REG_ON_SCHED, PDATA_W'({sched_fld(1'b1, 11'd500), sched_fld(1'b1, 11'd300),
                                      sched_fld(1'b1, 11'd1380), sched_fld(1'b1, 11'd60)}));
    cfg_write(REG_OFF_SCHED, PDATA_W'({sched_fld(1'b0, 11'd0), sched_fld(1'b1, 11'd300),
                                       sched_fld(1'b1, 11'd30), sched_fld(1'b1, 11'd120)}));
    send_item(mk_item(OP_TICK, 2'd0, 1'b0, 1'b0, 11'd0));
    send_item(mk_item(OP_DRIVE, 2'd0, 1'b1, 1'b0, 11'd0));
    send_item(mk_item(OP_TICK, 2'd0, 1'b0, 1'b0, 11'd0));   // same minute, skipped
    send_item(mk_item(OP_TICK, 2'd0, 1'b0, 1'b0, 11'd60));
    send_item(mk_item(OP_TICK, 2'd0, 1'b0, 1'b0, 11'd500));
    send_item(mk_item(OP_TICK, 2'd0, 1'b0, 1'b0, 11'd501));
    send_item(mk_item(OP_MAN_DRIVE, 2'd0, 1'b0, 1'b1, 11'd0));
    send_item(mk_item(OP_TICK, 2'd0, 1'b0, 1'b0, 11'd1400));
    send_item(mk_item(OP_SET_MANUAL, 2'd0, 1'b0, 1'b0, 11'd1400));
    send_item(mk_item(OP_SET_MANUAL, 2'd2, 1'b1, 1'b1, 11'd0));
    send_item(mk_item(OP_EVAL_NOW, 2'd1, 1'b0, 1'b0, 11'd61));
    send_item(mk_item(OP_SET_MANUAL, 2'd3, 1'b1, 1'b0, 11'd61));
    send_item(mk_item(OP_DRIVE, 2'd2, 1'b0, 1'b1, 11'd0));
    send_item(mk_item(OP_SPARE_LAST, 2'd3, 1'b1, 1'b1, 11'd2047));
    send_item(mk_item(OP_TICK, 2'd3, 1'b0, 1'b1, 11'd2047));
    send_item(mk_item(OP_EVAL_NOW, 2'd0, 1'b0, 1'b0, 11'd0));
    send_item(mk_item(OP_MAN_DRIVE, 2'd1, 1'b1, 1'b0, 11'd0));
    send_item(mk_item(OP_SET_MANUAL, 2'd0, 1'b1, 1'b0, 11'd300));
    drain();
    cfg_write(REG_AUTO, '0);
    send_item(mk_item(OP_TICK, 2'd0, 1'b0, 1'b0, 11'd700));  // minute not recorded
    drain();
    cfg_write(REG_AUTO, 64'd1);
    send_item(mk_item(OP_TICK, 2'd0, 1'b0, 1'b0, 11'd700));
    drain();
    // off-only schedule on ch3
    cfg_write(REG_ON_SCHED, '0);
    cfg_write(REG_OFF_SCHED, PDATA_W'({sched_fld(1'b1, 11'd600), 36'h0}));
    send_item(mk_item(OP_DRIVE, 2'd0, 1'b1, 1'b1, 11'd0));
    send_item(mk_item(OP_TICK, 2'd0, 1'b0, 1'b0, 11'd600));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      for (int k = 0; k < 4; k++)
        pool[k] = ($urandom_range(7) == 0) ? MIN_W'($urandom_range(2047))
                                           : MIN_W'($urandom_range(DAY_MINUTES - 1));
      case (p)
        0: begin
          cfg_write(REG_ON_SCHED, '0);
          cfg_write(REG_OFF_SCHED, '0);
          cfg_write(REG_AUTO, 64'd1);
        end
        1: begin
          cfg_write(REG_ON_SCHED, PDATA_W'({SCHED_W{1'b1}}));
          cfg_write(REG_OFF_SCHED, PDATA_W'({SCHED_W{1'b1}}));
          cfg_write(REG_AUTO, 64'd1);
        end
        2: begin
          cfg_write(REG_ON_SCHED, PDATA_W'(make_sched()));
          cfg_write(REG_OFF_SCHED, PDATA_W'(make_sched()));
          cfg_write(REG_AUTO, '0);
        end
        default: begin
          cfg_write(REG_ON_SCHED, PDATA_W'(make_sched()));
          cfg_write(REG_OFF_SCHED, PDATA_W'(make_sched()));
          cfg_write(REG_AUTO, 64'd1);
        end
      endcase
      mode = p % 4;
      idle_pct  = (mode == 1) ? 67 : (mode == 3) ? 19 : 0;
      stall_pct <= (mode == 2) ? 67 : (mode == 3) ? 19 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 3 && i == 40) hold_req <= hold_req + 1;
        if (p == 5 && i == 60) drain();
        send_item(random_item());
      end
    end
    drain();

    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
